// ===== rtl/double_step_line_rasterizer_assert.svh =====
// Assertion macros shared by the rasteriser RTL
`ifndef DOUBLE_STEP_LINE_RASTERIZER_ASSERT_SVH
`define DOUBLE_STEP_LINE_RASTERIZER_ASSERT_SVH

// implication checked on every edge outside reset
`define DSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication with the consequent checked in the next cycle
`define DSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/dslr_pkg.sv =====
`default_nettype none
package dslr_pkg;
	localparam int CoordBits = 10;
	localparam int ErrBits   = CoordBits + 5;
	localparam int GrpBits   = CoordBits - 1;
	localparam int QDepth    = 2;

	typedef logic [CoordBits-1:0] coord_t;
	typedef logic signed [ErrBits-1:0] err_t;

	typedef enum logic {OP_START = 1'b0, OP_ADVANCE = 1'b1} op_t;

	// item as it travels from front to back
	typedef struct packed {
		logic   op;
		coord_t fmaj;
		coord_t fmin;
		coord_t bmaj;
		coord_t bmin;
		coord_t dx;
		coord_t dy;
		logic   down;
		logic   swap;
		logic [7:0] color;
	} cmd_t;

	typedef struct packed {
		coord_t [3:0] px;
		coord_t [3:0] py;
		logic [3:0]   valid;
		logic [7:0]   color;
		logic         done;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/dslr_front.sv =====
`default_nettype none
module dslr_front import dslr_pkg::*; (
	input  wire logic            op,
	input  wire coord_t          xs,
	input  wire coord_t          ys,
	input  wire coord_t          xf,
	input  wire coord_t          yf,
	input  wire logic [7:0]      color,
	output cmd_t                 cmd
);
	logic   nx, ny, sw;
	coord_t adx, ady, a1, b1, a2, b2;

	always_comb begin
		nx  = xf < xs;
		ny  = yf < ys;
		adx = nx ? coord_t'(xs - xf) : coord_t'(xf - xs);
		ady = ny ? coord_t'(ys - yf) : coord_t'(yf - ys);
		sw  = ady > adx;
		a1 = sw ? ys : xs;
		b1 = sw ? xs : ys;
		a2 = sw ? yf : xf;
		b2 = sw ? xf : yf;
		cmd.op    = op;
		cmd.down  = nx != ny;
		cmd.swap  = sw;
		cmd.dx    = sw ? ady : adx;
		cmd.dy    = sw ? adx : ady;
		cmd.color = color;
		if (a1 > a2) begin
			cmd.fmaj = a2; cmd.fmin = b2; cmd.bmaj = a1; cmd.bmin = b1;
		end else begin
			cmd.fmaj = a1; cmd.fmin = b1; cmd.bmaj = a2; cmd.bmin = b2;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/dslr_queue.sv =====
`default_nettype none
module dslr_queue import dslr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic rd,
	output cmd_t      rdata,
	output logic      empty
);
	cmd_t mem_q [QDepth];
	logic rp_q, wp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'(QDepth);
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0; wp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end

`include "double_step_line_rasterizer_assert.svh"
	`DSL_ASSERT_IMP(a_q_bound, clk, arst_n, 1'b1, cnt_q <= 2'(QDepth))
	`DSL_ASSERT_NEXT(a_q_fill, clk, arst_n, wr && !full && !rd, !empty)
	`DSL_ASSERT_NEXT(a_q_keep, clk, arst_n, full && !rd, full)
endmodule
`default_nettype wire

// ===== rtl/dslr_back.sv =====
`default_nettype none
module dslr_back import dslr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_vld,
	output logic      cmd_rd,
	output res_t      res,
	output logic      res_vld,
	input  wire logic res_rd
);
	coord_t fmaj_q, fmin_q, bmaj_q, bmin_q;
	err_t   d_q, split_q, s1_q, s2_q;
	logic   down_q, swap_q, steep_q, act_q;
	logic [GrpBits-1:0] grp_q;
	logic [1:0] tail_q;
	logic [7:0] color_q;
	res_t   out_q;
	logic   ovld_q;

	logic   take;
	res_t   r;
	coord_t f, g, h, f0, f1, b0, b1;
	logic   p_fs, p_gs, p_even;
	err_t   dx_e, dy_e, e2;
	logic [CoordBits-1:0] dxm1;

	assign take    = cmd_vld && (!ovld_q || res_rd);
	assign cmd_rd  = take;
	assign res     = out_q;
	assign res_vld = ovld_q;

	function automatic logic [2*CoordBits-1:0] scr(logic s, coord_t mj, coord_t mn);
		scr = s ? {mn, mj} : {mj, mn};
	endfunction

	always_comb begin
		// pattern: first step / second step take minor move
		if (steep_q && d_q > 0) begin
			p_fs = 1'b1; p_gs = 1'b1;
		end else if (!steep_q && d_q < 0) begin
			p_fs = 1'b0; p_gs = 1'b0;
		end else if (d_q < split_q) begin
			p_fs = 1'b0; p_gs = 1'b1;
		end else begin
			p_fs = 1'b1; p_gs = 1'b0;
		end
		p_even = p_fs == p_gs;
		f = p_fs ? (down_q ? '1 : coord_t'(1)) : '0;
		g = p_gs ? (down_q ? '1 : coord_t'(1)) : '0;
		h = (steep_q && p_fs && !p_gs && !(d_q > split_q)) ? '0 : f;
		f0 = fmin_q + f;
		f1 = f0 + g;
		b0 = bmin_q - f;
		b1 = b0 - g;
		dx_e = err_t'({1'b0, cmd.dx});
		dy_e = err_t'({1'b0, cmd.dy});
		e2   = (dy_e <<< 2) - (dx_e <<< 1);
		dxm1 = cmd.dx - coord_t'(1);
		r = '0;
		if (cmd.op == OP_START) begin
			r.color = cmd.color;
			{r.px[0], r.py[0]} = scr(cmd.swap, cmd.fmaj, cmd.fmin);
			r.valid[0] = 1'b1;
			if (cmd.dx == '0) r.done = 1'b1;
			else begin
				{r.px[1], r.py[1]} = scr(cmd.swap, cmd.bmaj, cmd.bmin);
				r.valid[1] = 1'b1;
				r.done = dxm1 == '0;
			end
		end else begin
			r.color = color_q;
			r.done  = 1'b1;
			if (act_q) begin
				{r.px[0], r.py[0]} = scr(swap_q, fmaj_q + coord_t'(1), f0);
				r.valid[0] = 1'b1;
				if (grp_q != '0) begin
					{r.px[1], r.py[1]} = scr(swap_q, fmaj_q + coord_t'(2), f1);
					{r.px[2], r.py[2]} = scr(swap_q, bmaj_q - coord_t'(1), b0);
					{r.px[3], r.py[3]} = scr(swap_q, bmaj_q - coord_t'(2), b1);
					r.valid = 4'hF;
					r.done = grp_q == GrpBits'(1) && tail_q == 2'd0;
				end else begin
					if (tail_q > 2'd1) begin
						{r.px[1], r.py[1]} = scr(swap_q, fmaj_q + coord_t'(2), f1);
						r.valid[1] = 1'b1;
					end
					if (tail_q > 2'd2) begin
						{r.px[2], r.py[2]} =
							scr(swap_q, bmaj_q - coord_t'(1), bmin_q - h);
						r.valid[2] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= r;
			if (cmd.op == OP_START) begin
				fmaj_q <= cmd.fmaj; fmin_q <= cmd.fmin;
				bmaj_q <= cmd.bmaj; bmin_q <= cmd.bmin;
				down_q <= cmd.down; swap_q <= cmd.swap;
				grp_q  <= GrpBits'(dxm1[CoordBits-1:2]);
				tail_q <= dxm1[1:0];
				s2_q   <= e2;
				steep_q <= !e2[ErrBits-1];
				if (e2[ErrBits-1]) begin
					split_q <= dy_e <<< 1;
					s1_q    <= dy_e <<< 2;
					d_q     <= (dy_e <<< 2) - dx_e;
				end else begin
					split_q <= (dy_e - dx_e) <<< 1;
					s1_q    <= (dy_e - dx_e) <<< 2;
					d_q     <= ((dy_e - dx_e) <<< 2) + dx_e;
				end
			end else if (act_q && grp_q != '0) begin
				fmaj_q <= fmaj_q + coord_t'(2); fmin_q <= f1;
				bmaj_q <= bmaj_q - coord_t'(2); bmin_q <= b1;
				d_q    <= d_q + (p_even ? s1_q : s2_q);
				grp_q  <= grp_q - GrpBits'(1);
			end else if (act_q) begin
				tail_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			ovld_q  <= 1'b0;
			color_q <= '0;
		end else begin
			if (take) ovld_q <= 1'b1;
			else if (res_rd) ovld_q <= 1'b0;
			if (take) begin
				if (cmd.op == OP_START) begin
					act_q   <= cmd.dx != '0 && dxm1 != '0;
					color_q <= cmd.color;
				end else if (act_q) act_q <= !r.done;
			end
		end
	end

`include "double_step_line_rasterizer_assert.svh"
	`DSL_ASSERT_IMP(a_b_idle_mask, clk, arst_n,
		take && cmd.op == OP_ADVANCE && !act_q, r.valid == 4'h0 && r.done)
	`DSL_ASSERT_NEXT(a_b_done_idle, clk, arst_n,
		take && cmd.op == OP_ADVANCE && r.done, !act_q)
	`DSL_ASSERT_NEXT(a_b_hold, clk, arst_n, ovld_q && !res_rd && !take, $stable(out_q))
endmodule
`default_nettype wire

// ===== rtl/double_step_line_rasterizer.sv =====
`default_nettype none
// Symmetric double-step line rasteriser.
// Input queue port: push/full with opcode, endpoints and pen_color. A start
// (opcode 0) returns the ordered endpoints; each advance (opcode 1) returns a
// group of up to four pixels with a valid mask, line_done on the last group.
// Result queue port: empty/pop; the oldest result sits on the ports while
// empty is low.
// The front is combinational; an accepted beat is written into the command
// queue and from there loads the back-end output register once that register
// is free or being popped.
// Throughput: one beat per cycle while pop is held; the back end updates its
// cursors and decision value with one add and compare per advance.
// Reset empties the command queue and the result register and leaves the
// block idle; an advance while idle returns an empty mask with line_done set.
// When the receiver stalls the result register holds, the two-entry command
// queue fills, and full rises to stall the sender.
module double_step_line_rasterizer import dslr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        opcode,
	input  wire coord_t      x_start,
	input  wire coord_t      y_start,
	input  wire coord_t      x_finish,
	input  wire coord_t      y_finish,
	input  wire logic [7:0]  pen_color,
	output logic             empty,
	input  wire logic        pop,
	output coord_t           pix0_x,
	output coord_t           pix0_y,
	output coord_t           pix1_x,
	output coord_t           pix1_y,
	output coord_t           pix2_x,
	output coord_t           pix2_y,
	output coord_t           pix3_x,
	output coord_t           pix3_y,
	output logic [3:0]       pixel_valid,
	output logic [7:0]       pixel_color,
	output logic             line_done
);
	cmd_t fcmd, qcmd;
	logic qempty, qrd, rvld;
	res_t res;

	dslr_front u_front (
		.op(opcode), .xs(x_start), .ys(y_start), .xf(x_finish), .yf(y_finish),
		.color(pen_color), .cmd(fcmd)
	);

	dslr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(push), .wdata(fcmd), .full(full),
		.rd(qrd), .rdata(qcmd), .empty(qempty)
	);

	dslr_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(qcmd), .cmd_vld(!qempty), .cmd_rd(qrd),
		.res(res), .res_vld(rvld), .res_rd(pop)
	);

	assign empty       = !rvld;
	assign pix0_x      = res.px[0];
	assign pix0_y      = res.py[0];
	assign pix1_x      = res.px[1];
	assign pix1_y      = res.py[1];
	assign pix2_x      = res.px[2];
	assign pix2_y      = res.py[2];
	assign pix3_x      = res.px[3];
	assign pix3_y      = res.py[3];
	assign pixel_valid = res.valid;
	assign pixel_color = res.color;
	assign line_done   = res.done;
endmodule
`default_nettype wire

// ===== bench/tb_double_step_line_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_double_step_line_rasterizer;
	import dslr_pkg::*;

	typedef struct {
		logic [9:0] px [4];
		logic [9:0] py [4];
		logic [3:0] valid;
		logic [7:0] color;
		logic       done;
	} group_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic opcode = 1'b0;
	coord_t x_start = '0, y_start = '0, x_finish = '0, y_finish = '0;
	logic [7:0] pen_color = '0;
	logic full, empty;
	coord_t pix0_x, pix0_y, pix1_x, pix1_y, pix2_x, pix2_y, pix3_x, pix3_y;
	logic [3:0] pixel_valid;
	logic [7:0] pixel_color;
	logic line_done;

	double_step_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.x_start(x_start), .y_start(y_start), .x_finish(x_finish), .y_finish(y_finish),
		.pen_color(pen_color), .empty(empty), .pop(pop),
		.pix0_x(pix0_x), .pix0_y(pix0_y), .pix1_x(pix1_x), .pix1_y(pix1_y),
		.pix2_x(pix2_x), .pix2_y(pix2_y), .pix3_x(pix3_x), .pix3_y(pix3_y),
		.pixel_valid(pixel_valid), .pixel_color(pixel_color), .line_done(line_done)
	);

	// rasteriser state mirror
	int fmaj, fmin, bmaj, bmin, derr, split, step1, step2;
	bit down, swp, steep, active;
	int grp_left, tail;
	logic [7:0] lcolor = '0;

	group_t expected_groups [$];
	int errors = 0;
	bit no_idle = 1'b0;
	int stall_pct = 19;
	int quiet = 0;
	int beats_sent = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d want %0d", what, got, want);
	endtask

	function automatic void plot(ref group_t g, input int slot, input int mj, input int mn);
		g.px[slot] = swp ? mn[9:0] : mj[9:0];
		g.py[slot] = swp ? mj[9:0] : mn[9:0];
		g.valid[slot] = 1'b1;
	endfunction

	function automatic group_t predict_group(logic op, int a1, int b1, int a2, int b2,
			logic [7:0] col);
		group_t g;
		int dx, dy, t, s, pat, f, gg, h;
		bit nx, ny;
		for (int i = 0; i < 4; i++) begin
			g.px[i] = '0;
			g.py[i] = '0;
		end
		g.valid = '0;
		g.done = 1'b0;
		if (op == OP_START) begin
			dx = a2 - a1; dy = b2 - b1;
			nx = dx < 0; ny = dy < 0;
			if (nx) dx = -dx;
			if (ny) dy = -dy;
			lcolor = col;
			down = nx != ny;
			swp = dy > dx;
			if (swp) begin
				t = a1; a1 = b1; b1 = t;
				t = a2; a2 = b2; b2 = t;
				t = dx; dx = dy; dy = t;
			end
			if (a1 > a2) begin
				fmaj = a2; fmin = b2; bmaj = a1; bmin = b1;
			end else begin
				fmaj = a1; fmin = b1; bmaj = a2; bmin = b2;
			end
			g.color = lcolor;
			if (dx == 0) begin
				plot(g, 0, fmaj, fmin);
				g.done = 1'b1;
				active = 1'b0; grp_left = 0; tail = 0;
				return g;
			end
			grp_left = (dx - 1) / 4;
			tail = (dx - 1) % 4;
			step2 = 4 * dy - 2 * dx;
			steep = step2 >= 0;
			if (!steep) begin
				split = 2 * dy; step1 = 2 * split; derr = step1 - dx;
			end else begin
				split = 2 * (dy - dx); step1 = 2 * split; derr = step1 + dx;
			end
			plot(g, 0, fmaj, fmin);
			plot(g, 1, bmaj, bmin);
			active = grp_left != 0 || tail != 0;
			g.done = !active;
			return g;
		end
		g.color = lcolor;
		if (!active) begin
			g.done = 1'b1;
			return g;
		end
		s = down ? -1 : 1;
		if (steep && derr > 0) pat = 4;
		else if (!steep && derr < 0) pat = 1;
		else pat = (derr < split) ? 2 : 3;
		f = (pat == 3 || pat == 4) ? s : 0;
		gg = (pat == 2 || pat == 4) ? s : 0;
		if (grp_left != 0) begin
			fmaj += 1; fmin += f; plot(g, 0, fmaj, fmin);
			fmaj += 1; fmin += gg; plot(g, 1, fmaj, fmin);
			bmaj -= 1; bmin -= f; plot(g, 2, bmaj, bmin);
			bmaj -= 1; bmin -= gg; plot(g, 3, bmaj, bmin);
			derr += (pat == 1 || pat == 4) ? step1 : step2;
			grp_left--;
			if (grp_left == 0 && tail == 0) begin
				active = 1'b0;
				g.done = 1'b1;
			end
			return g;
		end
		h = f;
		if (steep && pat == 3 && !(derr > split)) h = 0;
		fmaj += 1; fmin += f; plot(g, 0, fmaj, fmin);
		if (tail > 1) begin
			fmaj += 1; fmin += gg; plot(g, 1, fmaj, fmin);
		end
		if (tail > 2) begin
			bmaj -= 1; bmin -= h; plot(g, 2, bmaj, bmin);
		end
		tail = 0;
		active = 1'b0;
		g.done = 1'b1;
		return g;
	endfunction

	// drop push; call only at an edge where push was not assigned yet
	task automatic hold_sender();
		push <= 1'b0;
	endtask

	task automatic send_beat(logic op, int a1, int b1, int a2, int b2, logic [7:0] col);
		if (!no_idle && $urandom_range(99) < stall_pct) begin
			push <= 1'b0;
			@(posedge clk);
			while (!no_idle && $urandom_range(99) < stall_pct) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		x_start <= a1[9:0]; y_start <= b1[9:0];
		x_finish <= a2[9:0]; y_finish <= b2[9:0];
		pen_color <= col;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_groups.push_back(predict_group(op, a1, b1, a2, b2, col));
		beats_sent++;
	endtask

	// start a line and walk it to the end, with an occasional early abandon
	task automatic draw_line(int a1, int b1, int a2, int b2, logic [7:0] col, bit cut);
		int n;
		send_beat(OP_START, a1, b1, a2, b2, col);
		n = 0;
		while (active && !(cut && n > 2)) begin
			send_beat(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom, 8'($urandom));
			n++;
		end
	endtask

	function automatic int rnd_len(int base);
		int l;
		l = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(40);
		if ($urandom_range(1)) l = -l;
		l = base + l;
		return l < 0 ? 0 : (l > 1023 ? 1023 : l);
	endfunction

	task automatic test_directed();
		draw_line(0, 0, 0, 0, 8'h00, 0);
		draw_line(1023, 1023, 1023, 1023, 8'hff, 0);
		send_beat(OP_ADVANCE, 0, 0, 0, 0, 8'h00);
		draw_line(5, 5, 6, 6, 8'h55, 0);
		draw_line(0, 0, 1023, 0, 8'haa, 1);
		draw_line(1023, 0, 0, 1023, 8'h0f, 1);
		draw_line(10, 3, 17, 6, 8'h12, 0);
		draw_line(10, 10, 3, 30, 8'h34, 0);
		draw_line(0, 0, 9, 7, 8'h81, 0);
		draw_line(20, 0, 13, 5, 8'h7e, 0);
		send_beat(OP_ADVANCE, 1023, 1023, 1023, 1023, 8'hff);
	endtask

	task automatic test_random_lines();
		int a1, b1;
		while (beats_sent < 900) begin
			// a long stretch with no idling on either side
			no_idle = beats_sent >= 300 && beats_sent < 550;
			a1 = $urandom_range(1023); b1 = $urandom_range(1023);
			if ($urandom_range(19) == 0)
				send_beat(OP_ADVANCE, $urandom, $urandom, $urandom, $urandom, 8'($urandom));
			else
				draw_line(a1, b1, rnd_len(a1), rnd_len(b1), 8'($urandom),
					$urandom_range(9) == 0);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		// hold the sender until every result is back
		hold_sender();
		wait (expected_groups.size() == 0);
		repeat (4) @(posedge clk);
		draw_line(100, 200, 140, 180, 8'h3c, 0);
	endtask

	// result checker
	always @(posedge clk) begin
		group_t w;
		if (arst_n && pop && !empty) begin
			if (expected_groups.size() == 0) begin
				errors++;
				$display("unexpected result beat");
			end else begin
				w = expected_groups.pop_front();
				if (pix0_x != w.px[0]) report("pix0_x", pix0_x, w.px[0]);
				if (pix0_y != w.py[0]) report("pix0_y", pix0_y, w.py[0]);
				if (pix1_x != w.px[1]) report("pix1_x", pix1_x, w.px[1]);
				if (pix1_y != w.py[1]) report("pix1_y", pix1_y, w.py[1]);
				if (pix2_x != w.px[2]) report("pix2_x", pix2_x, w.px[2]);
				if (pix2_y != w.py[2]) report("pix2_y", pix2_y, w.py[2]);
				if (pix3_x != w.px[3]) report("pix3_x", pix3_x, w.px[3]);
				if (pix3_y != w.py[3]) report("pix3_y", pix3_y, w.py[3]);
				if (pixel_valid != w.valid) report("pixel_valid", pixel_valid, w.valid);
				if (pixel_color != w.color) report("pixel_color", pixel_color, w.color);
				if (line_done != w.done) report("line_done", line_done, w.done);
			end
		end
		pop <= no_idle ? 1'b1 : ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 5000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random_lines();
		hold_sender();
		wait (expected_groups.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
